FILE: rtl/env_sensor_compensation_core_defines.svh
// Assertion macros shared by the compensation core RTL.
`ifndef ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define ESC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/esc_pkg.sv
// Shared types and constants of the sensor compensation core.
package esc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_TEMP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_LO = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_HI = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESS_9  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUM      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_HUM_6    = 3'd5;

  localparam int unsigned DivSteps = 64;

  localparam logic signed [33:0] PressFineOfs = 34'sd128000;
  localparam logic [63:0]        PressRawBase = 64'd1048576;
  localparam logic [63:0]        PressW47     = 64'h0000_8000_0000_0000;
  localparam logic [11:0]        PressScale   = 12'd3125;

  localparam logic [31:0] HumFineOfs = 32'd76800;
  localparam logic [31:0] HumRound   = 32'd16384;
  localparam logic [31:0] HumBias    = 32'd32768;
  localparam logic [31:0] HumOfs     = 32'd2097152;
  localparam logic [31:0] HumRound2  = 32'd8192;
  localparam logic [31:0] HumMax     = 32'd419430400;
  localparam logic [16:0] HumOutMax  = 17'd102400;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [15:0] h4;
    logic signed [15:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
  } side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [31:0] den;
    side_t       side;
  } quot_req_t;

  typedef struct packed {
    logic [63:0] quo;
    logic        zero;
    side_t       side;
  } quot_rsp_t;

endpackage

FILE: rtl/esc_if.sv
// Valid/ready channel interfaces for sensor items and compensated results.
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity, input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temperature_centi;
  logic [31:0] pressure_q24_8;
  logic [16:0] humidity_q22_10;

  modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  input ready);
  modport sink   (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                  output ready);
endinterface

FILE: rtl/env_sensor_compensation_core.sv
// Top level of the environmental sensor compensation core.
// Fully pipelined: one item is accepted every cycle while the output is not
// stalled; its result passes 11 front stages, a 66-stage divider that retires
// one quotient bit per step stage and 4 back stages ending in the output register.
// When a result waits at the output, the whole pipeline holds in place and
// in_ch.ready drops in the same cycle. Calibration registers are written through
// the cfg_ port; the user must write them only while no item is in flight, as the
// block does not enforce this. Unknown indexes are ignored.
`include "env_sensor_compensation_core_defines.svh"
module env_sensor_compensation_core (
  input  logic                          clk,
  input  logic                          rst_n,
  esc_in_if.sink                        in_ch,
  esc_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [esc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [esc_pkg::CfgDataW-1:0]  cfg_data
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_lo_r, press_hi_r, hum_cal_r;
  logic [15:0] press_9_r;
  logic [7:0]  hum_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_lo_r <= '0;
      press_hi_r <= '0;
      press_9_r  <= '0;
      hum_cal_r  <= '0;
      hum_6_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        esc_pkg::CFG_TEMP:     temp_cal_r <= cfg_data[47:0];
        esc_pkg::CFG_PRESS_LO: press_lo_r <= cfg_data;
        esc_pkg::CFG_PRESS_HI: press_hi_r <= cfg_data;
        esc_pkg::CFG_PRESS_9:  press_9_r  <= cfg_data[15:0];
        esc_pkg::CFG_HUM:      hum_cal_r  <= cfg_data;
        esc_pkg::CFG_HUM_6:    hum_6_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  esc_pkg::cal_t cal;
  always_comb begin
    cal.t1 = temp_cal_r[15:0];
    cal.t2 = temp_cal_r[31:16];
    cal.t3 = temp_cal_r[47:32];
    cal.p1 = press_lo_r[15:0];
    cal.p2 = press_lo_r[31:16];
    cal.p3 = press_lo_r[47:32];
    cal.p4 = press_lo_r[63:48];
    cal.p5 = press_hi_r[15:0];
    cal.p6 = press_hi_r[31:16];
    cal.p7 = press_hi_r[47:32];
    cal.p8 = press_hi_r[63:48];
    cal.p9 = press_9_r;
    cal.h1 = hum_cal_r[7:0];
    cal.h2 = hum_cal_r[23:8];
    cal.h3 = hum_cal_r[31:24];
    cal.h4 = hum_cal_r[47:32];
    cal.h5 = hum_cal_r[63:48];
    cal.h6 = hum_6_r;
  end

  logic adv;
  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic               req_valid, rsp_valid;
  esc_pkg::quot_req_t req;
  esc_pkg::quot_rsp_t rsp;

  esc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .raw_t     (in_ch.raw_temperature),
    .raw_p     (in_ch.raw_pressure),
    .raw_h     (in_ch.raw_humidity),
    .cal       (cal),
    .req_valid (req_valid),
    .req       (req)
  );

  esc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  esc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cal       (cal),
    .out_valid (out_ch.valid),
    .out_temp  (out_ch.temperature_centi),
    .out_press (out_ch.pressure_q24_8),
    .out_hum   (out_ch.humidity_q22_10)
  );

  `ESC_ASSERT_NOW(a_hum_range, clk, rst_n, out_ch.valid, out_ch.humidity_q22_10 <= esc_pkg::HumOutMax, "humidity result above clamp")

endmodule

FILE: rtl/esc_front.sv
// Front pipeline: fine temperature, temperature, humidity and the pressure divide operands.
module esc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic [19:0]          raw_t,
  input  logic [19:0]          raw_p,
  input  logic [15:0]          raw_h,
  input  esc_pkg::cal_t        cal,
  output logic                 req_valid,
  output esc_pkg::quot_req_t   req
);

  logic        vld_r [1:11];
  logic [19:0] rp_r  [1:8];
  logic [15:0] rh_r  [1:4];
  logic [31:0] tmp_r [4:11];

  // stage 1
  logic [31:0] ta, td, s1_m1_nxt, s1_dd_nxt, s1_m1_r, s1_dd_r;
  assign ta        = {15'd0, raw_t[19:3]} - {15'd0, cal.t1, 1'b0};
  assign td        = {16'd0, raw_t[19:4]} - {16'd0, cal.t1};
  assign s1_m1_nxt = ta * 32'(cal.t2);
  assign s1_dd_nxt = td * td;

  // stage 2
  logic signed [31:0] s2_v1_nxt, s2_sq;
  logic [31:0]        s2_e_nxt, s2_v1_r, s2_e_r;
  assign s2_v1_nxt = $signed(s1_m1_r) >>> 11;
  assign s2_sq     = $signed(s1_dd_r) >>> 12;
  assign s2_e_nxt  = s2_sq * 32'(cal.t3);

  // stage 3: fine temperature
  logic signed [31:0] s2_e_sh;
  logic [31:0]        fine_nxt, fine_r;
  assign s2_e_sh  = $signed(s2_e_r) >>> 14;
  assign fine_nxt = s2_v1_r + s2_e_sh;

  // stage 4
  logic [31:0]        fine5, hx;
  logic signed [31:0] s4_temp_nxt;
  logic signed [33:0] s4_pv_nxt, s4_pv_r;
  logic [31:0]        s4_m5_nxt, s4_m6_nxt, s4_m3_nxt, s4_m5_r, s4_m6_r, s4_m3_r;
  assign fine5       = fine_r + {fine_r[29:0], 2'b00} + 32'd128;
  assign s4_temp_nxt = $signed(fine5) >>> 8;
  assign s4_pv_nxt   = 34'($signed(fine_r)) - esc_pkg::PressFineOfs;
  assign hx          = fine_r - esc_pkg::HumFineOfs;
  assign s4_m5_nxt   = hx * 32'(cal.h5);
  assign s4_m6_nxt   = hx * 32'(cal.h6);
  assign s4_m3_nxt   = hx * {24'd0, cal.h3};

  // stage 5
  logic signed [67:0] vv_full;
  logic [63:0]        s5_vv_nxt, s5_vv_r;
  logic signed [49:0] s5_vp5_nxt, s5_vp2_nxt, s5_vp5_r, s5_vp2_r;
  logic [31:0]        ha, f2a_u;
  logic signed [31:0] s5_ha_nxt, s5_f1_nxt, f2a;
  logic [31:0]        s5_f2_nxt, s5_ha_r, s5_f1_r, s5_f2_r;
  assign vv_full    = s4_pv_r * s4_pv_r;
  assign s5_vv_nxt  = vv_full[63:0];
  assign s5_vp5_nxt = s4_pv_r * cal.p5;
  assign s5_vp2_nxt = s4_pv_r * cal.p2;
  assign ha         = {2'd0, rh_r[4], 14'd0} - {cal.h4[11:0], 20'd0} - s4_m5_r
                      + esc_pkg::HumRound;
  assign s5_ha_nxt  = $signed(ha) >>> 15;
  assign s5_f1_nxt  = $signed(s4_m6_r) >>> 10;
  assign f2a        = $signed(s4_m3_r) >>> 11;
  assign f2a_u      = f2a;
  assign s5_f2_nxt  = f2a_u + esc_pkg::HumBias;

  // stage 6: partial products of the 64 x 16 terms and the humidity product
  logic signed [48:0] s6_p6lo_nxt, s6_p3lo_nxt, s6_p6lo_r, s6_p3lo_r;
  logic [31:0]        s6_p6hi_nxt, s6_p3hi_nxt, s6_p6hi_r, s6_p3hi_r;
  logic signed [49:0] s6_vp5_r, s6_vp2_r;
  logic [31:0]        s6_b0_nxt, s6_b0_r, s6_ha_r;
  assign s6_p6lo_nxt = $signed({1'b0, s5_vv_r[31:0]}) * cal.p6;
  assign s6_p3lo_nxt = $signed({1'b0, s5_vv_r[31:0]}) * cal.p3;
  assign s6_p6hi_nxt = s5_vv_r[63:32] * 32'(cal.p6);
  assign s6_p3hi_nxt = s5_vv_r[63:32] * 32'(cal.p3);
  assign s6_b0_nxt   = s5_f1_r * s5_f2_r;

  // stage 7
  logic [63:0]        s7_v2a_nxt, s7_v3a_nxt, s7_v2a_r, s7_v3a_r;
  logic signed [49:0] s7_vp5_r, s7_vp2_r;
  logic signed [31:0] hb0;
  logic [31:0]        hb, s7_bh_nxt, s7_bh_r, s7_ha_r;
  assign s7_v2a_nxt = 64'(s6_p6lo_r) + {s6_p6hi_r, 32'd0};
  assign s7_v3a_nxt = 64'(s6_p3lo_r) + {s6_p3hi_r, 32'd0};
  assign hb0        = $signed(s6_b0_r) >>> 10;
  assign hb         = hb0;
  assign s7_bh_nxt  = (hb + esc_pkg::HumOfs) * 32'(cal.h2);

  // stage 8
  logic [63:0]        vp5w, vp2w, s8_v2_nxt, s8_w_nxt, s8_v2_r, s8_w_r;
  logic signed [63:0] v3sh;
  logic [31:0]        hbr, s8_ad_nxt, s8_ad_r;
  logic signed [31:0] hd;
  assign vp5w      = 64'(s7_vp5_r);
  assign vp2w      = 64'(s7_vp2_r);
  assign s8_v2_nxt = s7_v2a_r + {vp5w[46:0], 17'd0} + {{13{cal.p4[15]}}, cal.p4, 35'd0};
  assign v3sh      = $signed(s7_v3a_r) >>> 8;
  assign s8_w_nxt  = v3sh + {vp2w[51:0], 12'd0};
  assign hbr       = s7_bh_r + esc_pkg::HumRound2;
  assign hd        = $signed(hbr) >>> 14;
  assign s8_ad_nxt = s7_ha_r * hd;

  // stage 9
  logic [63:0]        px, pr, s9_n0_nxt, s9_n0_r;
  logic [47:0]        s9_xlo_nxt, s9_xlo_r;
  logic [31:0]        s9_xhi_nxt, s9_xhi_r;
  logic signed [31:0] hs;
  logic [31:0]        s9_ss_nxt, s9_ss_r, s9_ad_r;
  assign px         = s8_w_r + esc_pkg::PressW47;
  assign s9_xlo_nxt = px[31:0] * cal.p1;
  assign s9_xhi_nxt = px[63:32] * {16'd0, cal.p1};
  assign pr         = esc_pkg::PressRawBase - {44'd0, rp_r[8]};
  assign s9_n0_nxt  = {pr[32:0], 31'd0} - s8_v2_r;
  assign hs         = $signed(s8_ad_r) >>> 15;
  assign s9_ss_nxt  = hs * hs;

  // stage 10
  logic [63:0]        dp;
  logic [31:0]        s10_den_nxt, s10_den_r;
  logic [43:0]        s10_nlo_nxt, s10_nlo_r;
  logic [31:0]        s10_nhi_nxt, s10_nhi_r;
  logic signed [31:0] ssh;
  logic [31:0]        s10_k_nxt, s10_k_r, s10_ad_r;
  assign dp          = {16'd0, s9_xlo_r} + {s9_xhi_r, 32'd0};
  assign s10_den_nxt = {dp[63], dp[63:33]};
  assign s10_nlo_nxt = s9_n0_r[31:0] * esc_pkg::PressScale;
  assign s10_nhi_nxt = s9_n0_r[63:32] * {20'd0, esc_pkg::PressScale};
  assign ssh         = $signed(s9_ss_r) >>> 7;
  assign s10_k_nxt   = ssh * {24'd0, cal.h1};

  // stage 11: clamp humidity, join numerator
  logic [63:0]        s11_num_nxt, s11_num_r;
  logic [31:0]        s11_den_r, hy, hc;
  logic signed [31:0] ksh;
  logic [16:0]        s11_hum_nxt, s11_hum_r;
  assign s11_num_nxt = {20'd0, s10_nlo_r} + {s10_nhi_r, 32'd0};
  assign ksh         = $signed(s10_k_r) >>> 4;
  assign hy          = s10_ad_r - ksh;
  always_comb begin
    if (hy[31]) begin
      hc = '0;
    end else if (hy > esc_pkg::HumMax) begin
      hc = esc_pkg::HumMax;
    end else begin
      hc = hy;
    end
  end
  assign s11_hum_nxt = hc[28:12];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 11; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= in_valid;
      for (int i = 2; i <= 11; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rp_r[1] <= raw_p;
      for (int i = 2; i <= 8; i++) rp_r[i] <= rp_r[i-1];
      rh_r[1] <= raw_h;
      for (int i = 2; i <= 4; i++) rh_r[i] <= rh_r[i-1];
      tmp_r[4] <= s4_temp_nxt;
      for (int i = 5; i <= 11; i++) tmp_r[i] <= tmp_r[i-1];
      s1_m1_r   <= s1_m1_nxt;
      s1_dd_r   <= s1_dd_nxt;
      s2_v1_r   <= s2_v1_nxt;
      s2_e_r    <= s2_e_nxt;
      fine_r    <= fine_nxt;
      s4_pv_r   <= s4_pv_nxt;
      s4_m5_r   <= s4_m5_nxt;
      s4_m6_r   <= s4_m6_nxt;
      s4_m3_r   <= s4_m3_nxt;
      s5_vv_r   <= s5_vv_nxt;
      s5_vp5_r  <= s5_vp5_nxt;
      s5_vp2_r  <= s5_vp2_nxt;
      s5_ha_r   <= s5_ha_nxt;
      s5_f1_r   <= s5_f1_nxt;
      s5_f2_r   <= s5_f2_nxt;
      s6_p6lo_r <= s6_p6lo_nxt;
      s6_p3lo_r <= s6_p3lo_nxt;
      s6_p6hi_r <= s6_p6hi_nxt;
      s6_p3hi_r <= s6_p3hi_nxt;
      s6_vp5_r  <= s5_vp5_r;
      s6_vp2_r  <= s5_vp2_r;
      s6_b0_r   <= s6_b0_nxt;
      s6_ha_r   <= s5_ha_r;
      s7_v2a_r  <= s7_v2a_nxt;
      s7_v3a_r  <= s7_v3a_nxt;
      s7_vp5_r  <= s6_vp5_r;
      s7_vp2_r  <= s6_vp2_r;
      s7_bh_r   <= s7_bh_nxt;
      s7_ha_r   <= s6_ha_r;
      s8_v2_r   <= s8_v2_nxt;
      s8_w_r    <= s8_w_nxt;
      s8_ad_r   <= s8_ad_nxt;
      s9_xlo_r  <= s9_xlo_nxt;
      s9_xhi_r  <= s9_xhi_nxt;
      s9_n0_r   <= s9_n0_nxt;
      s9_ss_r   <= s9_ss_nxt;
      s9_ad_r   <= s8_ad_r;
      s10_den_r <= s10_den_nxt;
      s10_nlo_r <= s10_nlo_nxt;
      s10_nhi_r <= s10_nhi_nxt;
      s10_k_r   <= s10_k_nxt;
      s10_ad_r  <= s9_ad_r;
      s11_num_r <= s11_num_nxt;
      s11_den_r <= s10_den_r;
      s11_hum_r <= s11_hum_nxt;
    end
  end

  assign req_valid     = vld_r[11];
  assign req.num       = s11_num_r;
  assign req.den       = s11_den_r;
  assign req.side.temp = tmp_r[11];
  assign req.side.hum  = s11_hum_r;

endmodule

FILE: rtl/esc_div.sv
// Pipelined signed 64 / 32 divider, one quotient bit per step stage, with side data.
`include "env_sensor_compensation_core_defines.svh"
module esc_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                req_valid,
  input  esc_pkg::quot_req_t  req,
  output logic                rsp_valid,
  output esc_pkg::quot_rsp_t  rsp
);

  localparam int unsigned N = esc_pkg::DivSteps;

  logic                vld_r  [0:N];
  logic [31:0]         rem_r  [0:N];
  logic [63:0]         quo_r  [0:N];
  logic [31:0]         div_r  [0:N];
  logic                neg_r  [0:N];
  logic                zero_r [0:N];
  esc_pkg::side_t      side_r [0:N];

  logic [63:0] ma;
  logic [31:0] mb;
  assign ma = req.num[63] ? (64'd0 - req.num) : req.num;
  assign mb = req.den[31] ? (32'd0 - req.den) : req.den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= req_valid;
      for (int i = 1; i <= N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= '0;
      quo_r[0]  <= ma;
      div_r[0]  <= mb;
      neg_r[0]  <= req.num[63] ^ req.den[31];
      zero_r[0] <= (req.den == 32'd0);
      side_r[0] <= req.side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [32:0] trial, diff;
    logic        take;
    assign trial = {rem_r[k], quo_r[k][63]};
    assign diff  = trial - {1'b0, div_r[k]};
    assign take  = !diff[32];
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1]  <= take ? diff[31:0] : trial[31:0];
        quo_r[k+1]  <= {quo_r[k][62:0], take};
        div_r[k+1]  <= div_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  logic vld_o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (adv) begin
      vld_o_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.quo  <= neg_r[N] ? (64'd0 - quo_r[N]) : quo_r[N];
      rsp.zero <= zero_r[N];
      rsp.side <= side_r[N];
    end
  end

  assign rsp_valid = vld_o_r;

  `ESC_ASSERT_NOW(a_rem_below_div, clk, rst_n, vld_r[N] && !zero_r[N], rem_r[N] < div_r[N], "divider remainder not below divisor")
  `ESC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv && vld_r[N], $stable(quo_r[N]) && vld_r[N], "divider stage moved during stall")

endmodule

FILE: rtl/esc_back.sv
// Back pipeline: pressure corrections after the divide and the output register.
module esc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                rsp_valid,
  input  esc_pkg::quot_rsp_t  rsp,
  input  esc_pkg::cal_t       cal,
  output logic                out_valid,
  output logic [31:0]         out_temp,
  output logic [31:0]         out_press,
  output logic [16:0]         out_hum
);

  logic vld_r [1:4];
  logic           zero_r [1:3];
  esc_pkg::side_t side_r [1:3];
  logic [63:0]    q0_r   [1:3];

  // Q1: q = p >> 13, p9 * q, p8 * p partials
  logic signed [63:0] qsh;
  logic signed [50:0] q1_q_nxt, q1_q_r;
  logic signed [66:0] a_full;
  logic [63:0]        q1_a_r;
  logic signed [48:0] q1_ulo_nxt, q1_ulo_r;
  logic [31:0]        q1_uhi_nxt, q1_uhi_r;
  assign qsh        = $signed(rsp.quo) >>> 13;
  assign q1_q_nxt   = qsh[50:0];
  assign a_full     = q1_q_nxt * cal.p9;
  assign q1_ulo_nxt = $signed({1'b0, rsp.quo[31:0]}) * cal.p8;
  assign q1_uhi_nxt = rsp.quo[63:32] * 32'(cal.p8);

  // Q2: (p9 * q) * q partials, p8 * p partial sum
  logic [63:0] q2_m1_nxt, q2_m1_r, q2_u_nxt, q2_u_r;
  logic [31:0] q2_m2_nxt, q2_m3_nxt, q2_m2_r, q2_m3_r;
  assign q2_m1_nxt = q1_a_r[31:0] * q1_q_r[31:0];
  assign q2_m2_nxt = q1_a_r[63:32] * q1_q_r[31:0];
  assign q2_m3_nxt = q1_a_r[31:0] * {{13{q1_q_r[50]}}, q1_q_r[50:32]};
  assign q2_u_nxt  = 64'(q1_ulo_r) + {q1_uhi_r, 32'd0};

  // Q3
  logic [31:0]        mid;
  logic [63:0]        tq, q3_t_r, q3_u_r;
  logic signed [63:0] q3_t_nxt, q3_u_nxt;
  assign mid      = q2_m2_r + q2_m3_r;
  assign tq       = q2_m1_r + {mid, 32'd0};
  assign q3_t_nxt = $signed(tq) >>> 25;
  assign q3_u_nxt = $signed(q2_u_r) >>> 19;

  // Q4: final sum into the output register
  logic [63:0]        psum;
  logic signed [63:0] psh;
  logic [31:0]        press_nxt;
  assign psum      = q0_r[3] + q3_t_r + q3_u_r;
  assign psh       = $signed(psum) >>> 8;
  assign press_nxt = zero_r[3] ? 32'd0
                   : psh[31:0] + {{12{cal.p7[15]}}, cal.p7, 4'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 4; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[1] <= rsp_valid;
      for (int i = 2; i <= 4; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r[1] <= rsp.zero;
      side_r[1] <= rsp.side;
      q0_r[1]   <= rsp.quo;
      for (int i = 2; i <= 3; i++) begin
        zero_r[i] <= zero_r[i-1];
        side_r[i] <= side_r[i-1];
        q0_r[i]   <= q0_r[i-1];
      end
      q1_q_r    <= q1_q_nxt;
      q1_a_r    <= a_full[63:0];
      q1_ulo_r  <= q1_ulo_nxt;
      q1_uhi_r  <= q1_uhi_nxt;
      q2_m1_r   <= q2_m1_nxt;
      q2_m2_r   <= q2_m2_nxt;
      q2_m3_r   <= q2_m3_nxt;
      q2_u_r    <= q2_u_nxt;
      q3_t_r    <= q3_t_nxt;
      q3_u_r    <= q3_u_nxt;
      out_press <= press_nxt;
      out_temp  <= side_r[3].temp;
      out_hum   <= side_r[3].hum;
    end
  end

  assign out_valid = vld_r[4];

endmodule

FILE: sim/testbench.sv
// Testbench for the sensor compensation core: directed and random readings checked against a predictor.
`timescale 1ns / 1ps
module testbench;

  localparam logic [esc_pkg::CfgIdxW-1:0] CfgNoReg = esc_pkg::CFG_HUM_6 + 3'd1;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    bit [31:0] temp;
    bit [31:0] press;
    bit [16:0] hum;
  } comp_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [esc_pkg::CfgIdxW-1:0] cfg_index;
  logic [esc_pkg::CfgDataW-1:0] cfg_data;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  env_sensor_compensation_core u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bit [63:0] cal_copy [0:5];
  comp_result_t pending_results[$];
  int unsigned mismatches;
  int unsigned readings_sent;
  int unsigned results_checked;
  int unsigned cycle_count;
  bit calm;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit [31:0] asr32(bit [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [63:0] asr64(bit [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [31:0] sx16(bit [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  function automatic bit [63:0] sx16w(bit [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic bit [31:0] fine_temp(bit [31:0] adc);
    bit [31:0] t1, t2, t3, v1, d, v2;
    t1 = {16'd0, cal_copy[0][15:0]};
    t2 = sx16(cal_copy[0][31:16]);
    t3 = sx16(cal_copy[0][47:32]);
    v1 = asr32(((adc >> 3) - (t1 << 1)) * t2, 11);
    d = (adc >> 4) - t1;
    v2 = asr32(asr32(d * d, 12) * t3, 14);
    return v1 + v2;
  endfunction

  function automatic bit [31:0] comp_pressure(bit [31:0] fine, bit [31:0] adc);
    bit [63:0] lo, hi, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    bit [63:0] v1, v2, p, q, num, ma, mb, quo;
    lo = cal_copy[1];
    hi = cal_copy[2];
    p1 = {48'd0, lo[15:0]};
    p2 = sx16w(lo[31:16]);
    p3 = sx16w(lo[47:32]);
    p4 = sx16w(lo[63:48]);
    p5 = sx16w(hi[15:0]);
    p6 = sx16w(hi[31:16]);
    p7 = sx16w(hi[47:32]);
    p8 = sx16w(hi[63:48]);
    p9 = sx16w(cal_copy[3][15:0]);
    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) return 32'd0;
    p = 64'd1048576 - {32'd0, adc};
    num = ((p << 31) - v2) * 64'd3125;
    // signed divide, truncating toward zero
    ma = num[63] ? -num : num;
    mb = v1[63] ? -v1 : v1;
    quo = ma / mb;
    p = (num[63] != v1[63]) ? -quo : quo;
    q = asr64(p, 13);
    v1 = asr64(p9 * q * q, 25);
    v2 = asr64(p8 * p, 19);
    p = asr64(p + v1 + v2, 8) + (p7 << 4);
    return p[31:0];
  endfunction

  function automatic bit [16:0] comp_humidity(bit [31:0] fine, bit [31:0] adc);
    bit [63:0] c;
    bit [31:0] h1, h2, h3, h4, h5, h6, x, a, b, d, s;
    c = cal_copy[4];
    h1 = {24'd0, c[7:0]};
    h2 = sx16(c[23:8]);
    h3 = {24'd0, c[31:24]};
    h4 = sx16(c[47:32]);
    h5 = sx16(c[63:48]);
    h6 = {{24{cal_copy[5][7]}}, cal_copy[5][7:0]};
    x = fine - 32'd76800;
    a = asr32((adc << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    b = asr32(asr32(x * h6, 10) * (asr32(x * h3, 11) + 32'd32768), 10) + 32'd2097152;
    d = asr32(b * h2 + 32'd8192, 14);
    x = a * d;
    s = asr32(x, 15);
    x = x - asr32(asr32(s * s, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    if (x > 32'd419430400) x = 32'd419430400;
    return x[28:12];
  endfunction

  function automatic comp_result_t compensate(bit [19:0] rt, bit [19:0] rp, bit [15:0] rh);
    comp_result_t r;
    bit [31:0] fine;
    fine = fine_temp({12'd0, rt});
    r.temp = asr32(fine * 32'd5 + 32'd128, 8);
    r.press = comp_pressure(fine, {12'd0, rp});
    r.hum = comp_humidity(fine, {16'd0, rh});
    return r;
  endfunction

  task automatic report_mismatch(string field, bit [31:0] got, bit [31:0] exp_val);
    $display("MISMATCH %s: got %h expected %h (result %0d)", field, got, exp_val,
             results_checked);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    comp_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", out_ch.temperature_centi, 32'd0);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.temperature_centi !== e.temp)
          report_mismatch("temperature_centi", out_ch.temperature_centi, e.temp);
        if (out_ch.pressure_q24_8 !== e.press)
          report_mismatch("pressure_q24_8", out_ch.pressure_q24_8, e.press);
        if (out_ch.humidity_q22_10 !== e.hum)
          report_mismatch("humidity_q22_10", {15'd0, out_ch.humidity_q22_10}, {15'd0, e.hum});
      end
      results_checked++;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_reading(bit [19:0] rt, bit [19:0] rp, bit [15:0] rh);
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.raw_temperature <= rt;
    in_ch.raw_pressure <= rp;
    in_ch.raw_humidity <= rh;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(compensate(rt, rp, rh));
    readings_sent++;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_cal(logic [esc_pkg::CfgIdxW-1:0] idx, bit [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      esc_pkg::CFG_TEMP:     cal_copy[0] = value & 64'hFFFF_FFFF_FFFF;
      esc_pkg::CFG_PRESS_LO: cal_copy[1] = value;
      esc_pkg::CFG_PRESS_HI: cal_copy[2] = value;
      esc_pkg::CFG_PRESS_9:  cal_copy[3] = value & 64'hFFFF;
      esc_pkg::CFG_HUM:      cal_copy[4] = value;
      esc_pkg::CFG_HUM_6:    cal_copy[5] = value & 64'hFF;
      default: ;
    endcase
  endtask

  task automatic load_cal(bit [63:0] t, bit [63:0] plo, bit [63:0] phi, bit [63:0] p9,
                          bit [63:0] h, bit [63:0] h6);
    write_cal(esc_pkg::CFG_TEMP, t);
    write_cal(esc_pkg::CFG_PRESS_LO, plo);
    write_cal(esc_pkg::CFG_PRESS_HI, phi);
    write_cal(esc_pkg::CFG_PRESS_9, p9);
    write_cal(esc_pkg::CFG_HUM, h);
    write_cal(esc_pkg::CFG_HUM_6, h6);
  endtask

  task automatic load_typical_cal;
    load_cal(64'({16'hFC18, 16'd26435, 16'd27504}),
             {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
             {-16'sd14600, 16'd15500, -16'sd7, 16'd140},
             64'd6000,
             {16'd50, 16'd313, 8'd0, 16'd362, 8'd75},
             64'd30);
  endtask

  function automatic bit [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  task automatic send_random_full(int n);
    repeat (n) send_reading(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  task automatic send_random_typical(int n);
    repeat (n) send_reading(20'($urandom_range(600000, 400000)),
                            20'($urandom_range(550000, 250000)), 16'($urandom));
  endtask

  // all calibration words zero: pressure divisor is zero
  task automatic test_zero_calibration;
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_random_full(10);
    drain();
  endtask

  task automatic test_typical_extremes;
    load_typical_cal();
    write_cal(CfgNoReg, rand64());
    write_cal(CfgNoReg + 3'd1, rand64());
    send_reading(20'd519888, 20'd415148, 16'd30000);
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_reading(20'd0, 20'hFFFFF, 16'hFFFF);
    send_reading(20'hFFFFF, 20'd0, 16'd0);
    send_reading(20'd440064, 20'd415148, 16'd0);   // fine term near zero
    send_reading(20'd519888, 20'd415148, 16'hFFFF); // humidity clamps high
    drain();
  endtask

  task automatic test_random_typical;
    send_random_typical(200);
    drain();
  endtask

  task automatic test_calm_stretch;
    calm = 1'b1;
    send_random_typical(60);
    send_random_full(40);
    calm = 1'b0;
    drain();
  endtask

  // all-ones and sign-extreme calibration words
  task automatic test_extreme_calibration;
    load_cal(64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFF);
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_random_full(40);
    drain();
    load_cal(64'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
             64'h8000, 64'h8000_8000_FF80_00FF, 64'h80);
    send_reading(20'd0, 20'd0, 16'd0);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_random_full(40);
    drain();
    load_cal(64'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
             64'h7FFF, 64'h7FFF_7FFF_FF7F_FFFF, 64'h7F);
    send_random_full(40);
    drain();
  endtask

  task automatic test_random_calibration;
    repeat (6) begin
      load_cal(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      send_random_full(25);
      drain();
    end
    load_typical_cal();
    send_random_typical(60);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.raw_temperature = '0;
    in_ch.raw_pressure = '0;
    in_ch.raw_humidity = '0;
    out_ch.ready = 1'b0;
    foreach (cal_copy[i]) cal_copy[i] = 64'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_calibration();
    test_typical_extremes();
    test_random_typical();
    test_calm_stretch();
    test_extreme_calibration();
    test_random_calibration();

    repeat (100) @(posedge clk);
    $display("Covered %0d sensor readings, %0d results checked, over zero, typical,",
             readings_sent, results_checked);
    $display("extreme and random calibration sets; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
